// ===== rtl/sesq_pkg.sv =====
package sesq_pkg;

    // Request codes carried on the mode field.
    typedef enum logic [2:0] {
        MODE_WREN        = 3'd0,
        MODE_WRITE       = 3'd1,
        MODE_READ        = 3'd2,
        MODE_RDSR        = 3'd3,
        MODE_BURST_START = 3'd4,
        MODE_BURST_BYTE  = 3'd5,
        MODE_MISO_BIT    = 3'd6
    } mode_t;

    // Serial EEPROM opcodes.
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;

    // Number of bits sampled by a read or status read.
    localparam logic [3:0] READ_BITS = 4'd8;

    // Cell segments, in the order the back end plays them out.
    localparam int SEG_COUNT = 9;
    typedef logic [SEG_COUNT-1:0] seg_mask_t;

    localparam seg_mask_t SEG_DATA_FIRST = 9'b000000001; // burst byte, 8 cells
    localparam seg_mask_t SEG_WAIT       = 9'b000000010; // deselect with write-cycle wait
    localparam seg_mask_t SEG_WREN       = 9'b000000100; // enable opcode plus deselect
    localparam seg_mask_t SEG_OPCODE     = 9'b000001000; // command opcode, 8 cells
    localparam seg_mask_t SEG_ADDRESS    = 9'b000010000; // address, ADDRESS_BITS cells
    localparam seg_mask_t SEG_DATA_LAST  = 9'b000100000; // single write byte, 8 cells
    localparam seg_mask_t SEG_DESELECT   = 9'b001000000; // plain deselect
    localparam seg_mask_t SEG_SAMPLE     = 9'b010000000; // one sampling clock cell
    localparam seg_mask_t SEG_READ_DONE  = 9'b100000000; // deselect carrying the read byte

    // One classified request, as queued between front and back.
    typedef struct packed {
        seg_mask_t   segs;
        logic [7:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  read_value;
    } desc_t;

endpackage

// ===== rtl/spi_eeprom_command_sequencer.sv =====
// Command sequencer for a 25xx-style SPI EEPROM. Each request becomes a run of
// serial bit cells on the m_ channel, one cell per clock cycle while m_ready is held
// high: a single write takes 9 + 8 + ADDRESS_BITS + 8 + 1 cells,
// a read 8 + ADDRESS_BITS cells followed by one cell per miso bit and a second
// one for the eighth bit, a status read 8 cells, a burst start 17 + ADDRESS_BITS
// cells, and a burst byte 8 or 9 cells, or 26 + ADDRESS_BITS cells when it closes
// a page and the write restarts. The serializer in the back end sets the rate at
// one cell a cycle; a two-entry request queue lets the front end take new
// requests while cells still stream out, and s_ready drops only while that queue
// is full. The page offset of a burst start address is found by a reciprocal
// multiply in the accepting cycle and a subtraction after it, with no stall.
module spi_eeprom_command_sequencer
    import sesq_pkg::*;
#(
    parameter int PAGE_BYTES   = 16,
    parameter int ADDRESS_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic        s_last_byte,
    input  logic        s_miso_bit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_select_level,
    output logic        m_clock_pulse,
    output logic        m_mosi_level,
    output logic        m_sample_cell,
    output logic        m_wait_write_cycle,
    output logic [7:0]  m_read_value,
    output logic        m_read_valid,
    output logic        m_last
);

    localparam int QUEUE_DEPTH = 2;

    logic  push_valid, push_ready, q_valid, q_pop;
    desc_t push_desc, q_desc;

    // Front end: classifies requests and tracks burst and read state.
    sesq_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .s_last_byte  (s_last_byte),
        .s_miso_bit   (s_miso_bit),
        .push_valid   (push_valid),
        .push_desc    (push_desc),
        .push_ready   (push_ready)
    );

    // Request queue between the two halves.
    sesq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_desc   (q_desc),
        .pop        (q_pop)
    );

    // Back end: plays each request out as serial cells.
    sesq_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_desc             (q_desc),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_select_level     (m_select_level),
        .m_clock_pulse      (m_clock_pulse),
        .m_mosi_level       (m_mosi_level),
        .m_sample_cell      (m_sample_cell),
        .m_wait_write_cycle (m_wait_write_cycle),
        .m_read_value       (m_read_value),
        .m_read_valid       (m_read_valid),
        .m_last             (m_last)
    );

    // A write-cycle wait is always followed by the restarted write header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wait_write_cycle |-> !m_last)
        else $error("write-cycle wait marked as final cell");

    // The assembled read byte only rides on a deselect cell that ends the request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_valid |-> m_select_level && !m_clock_pulse && m_last)
        else $error("read byte delivered on a wrong cell");

    // A sampling cell is a selected clock cell with the output line low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sample_cell |-> !m_select_level && m_clock_pulse && !m_mosi_level)
        else $error("malformed sampling cell");

    // A completed transfer of a cell that was not final leaves more cells queued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("cell run broken before its final cell");

endmodule

// ===== rtl/sesq_front.sv =====
module sesq_front
    import sesq_pkg::*;
#(
    parameter int PAGE_BYTES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic        s_last_byte,
    input  logic        s_miso_bit,
    output logic        push_valid,
    output desc_t       push_desc,
    input  logic        push_ready
);

    localparam int OFF_W = (PAGE_BYTES > 2) ? $clog2(PAGE_BYTES) : 1;

    // Reciprocal of the page size, exact for every 16-bit address.
    localparam int          RECIP_SHIFT = 16 + $clog2(PAGE_BYTES);
    localparam logic [16:0] PAGE_RECIP  = 17'(((64'd1 << RECIP_SHIFT) + 64'(PAGE_BYTES)
                                               - 64'd1) / 64'(PAGE_BYTES));

    logic [15:0]      burst_address_reg, burst_address_next;
    logic             burst_open_reg, burst_open_next;
    logic [3:0]       read_left_reg, read_left_next;
    logic [7:0]       read_shift_reg, read_shift_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [15:0]      page_quot_reg, page_quot_next;
    logic             offset_stale_reg, offset_stale_next;
    logic [32:0]      recip_product;
    logic [15:0]      page_base;
    logic [OFF_W-1:0] cur_offset;
    logic             accept;
    logic             boundary;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Page number of a burst start address, and the offset within the page once it is known.
    assign recip_product = 33'(s_address) * 33'(PAGE_RECIP);
    assign page_base     = page_quot_reg * 16'(PAGE_BYTES);
    assign cur_offset    = offset_stale_reg ? OFF_W'(burst_address_reg - page_base) : offset_reg;
    assign boundary      = (cur_offset == OFF_W'(PAGE_BYTES - 1));

    // Request classification and sequencer state.
    always_comb begin
        burst_address_next = burst_address_reg;
        burst_open_next    = burst_open_reg;
        read_left_next     = read_left_reg;
        read_shift_next    = read_shift_reg;
        offset_next        = offset_reg;
        page_quot_next     = page_quot_reg;
        offset_stale_next  = offset_stale_reg;

        push_desc.segs       = '0;
        push_desc.opcode     = OP_WRITE;
        push_desc.address    = s_address;
        push_desc.data       = s_write_data;
        push_desc.read_value = 8'd0;

        if (offset_stale_reg) begin
            offset_next       = cur_offset;
            offset_stale_next = 1'b0;
        end

        if (accept) begin
            if (read_left_reg != 4'd0) begin
                if (mode_t'(s_mode) == MODE_MISO_BIT) begin
                    read_shift_next = {read_shift_reg[6:0], s_miso_bit};
                    read_left_next  = read_left_reg - 4'd1;
                    push_desc.read_value = read_shift_next;
                    push_desc.segs = SEG_SAMPLE;
                    if (read_left_reg == 4'd1) begin
                        push_desc.segs = SEG_SAMPLE | SEG_READ_DONE;
                    end
                end
            end else if (burst_open_reg) begin
                if (mode_t'(s_mode) == MODE_BURST_BYTE) begin
                    burst_address_next = burst_address_reg + 16'd1;
                    push_desc.address  = burst_address_next;
                    if (burst_address_reg == 16'hFFFF || boundary) begin
                        offset_next = '0;
                    end else begin
                        offset_next = cur_offset + OFF_W'(1);
                    end
                    if (s_last_byte) begin
                        push_desc.segs  = SEG_DATA_FIRST | SEG_DESELECT;
                        burst_open_next = 1'b0;
                    end else if (boundary) begin
                        push_desc.segs = SEG_DATA_FIRST | SEG_WAIT | SEG_WREN
                                       | SEG_OPCODE | SEG_ADDRESS;
                    end else begin
                        push_desc.segs = SEG_DATA_FIRST;
                    end
                end
            end else begin
                case (mode_t'(s_mode))
                    MODE_WREN: begin
                        push_desc.segs = SEG_WREN;
                    end
                    MODE_WRITE: begin
                        push_desc.segs = SEG_WREN | SEG_OPCODE | SEG_ADDRESS
                                       | SEG_DATA_LAST | SEG_DESELECT;
                    end
                    MODE_READ: begin
                        push_desc.opcode = OP_READ;
                        push_desc.segs   = SEG_OPCODE | SEG_ADDRESS;
                        read_left_next   = READ_BITS;
                        read_shift_next  = 8'd0;
                    end
                    MODE_RDSR: begin
                        push_desc.opcode = OP_RDSR;
                        push_desc.segs   = SEG_OPCODE;
                        read_left_next   = READ_BITS;
                        read_shift_next  = 8'd0;
                    end
                    MODE_BURST_START: begin
                        push_desc.segs     = SEG_WREN | SEG_OPCODE | SEG_ADDRESS;
                        burst_address_next = s_address;
                        burst_open_next    = 1'b1;
                        page_quot_next     = 16'(recip_product >> RECIP_SHIFT);
                        offset_stale_next  = 1'b1;
                    end
                    default: begin
                        push_desc.segs = '0;
                    end
                endcase
            end
        end
    end

    assign push_valid = accept && (push_desc.segs != '0);

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_address_reg <= '0;
            burst_open_reg    <= 1'b0;
            read_left_reg     <= '0;
            read_shift_reg    <= '0;
            offset_reg        <= '0;
            page_quot_reg     <= '0;
            offset_stale_reg  <= 1'b0;
        end else begin
            burst_address_reg <= burst_address_next;
            burst_open_reg    <= burst_open_next;
            read_left_reg     <= read_left_next;
            read_shift_reg    <= read_shift_next;
            offset_reg        <= offset_next;
            page_quot_reg     <= page_quot_next;
            offset_stale_reg  <= offset_stale_next;
        end
    end

endmodule

// ===== rtl/sesq_queue.sv =====
module sesq_queue
    import sesq_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    input  desc_t push_desc,
    output logic  push_ready,
    output logic  pop_valid,
    output desc_t pop_desc,
    input  logic  pop
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Descriptor storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/sesq_back.sv =====
module sesq_back
    import sesq_pkg::*;
#(
    parameter int ADDRESS_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  desc_t      q_desc,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_select_level,
    output logic       m_clock_pulse,
    output logic       m_mosi_level,
    output logic       m_sample_cell,
    output logic       m_wait_write_cycle,
    output logic [7:0] m_read_value,
    output logic       m_read_valid,
    output logic       m_last
);

    localparam int MAX_LEN = (ADDRESS_BITS > 9) ? ADDRESS_BITS : 9;
    localparam int CNT_W   = $clog2(MAX_LEN);

    desc_t            desc_reg, cur;
    seg_mask_t        segs_reg, segs_next, cur_segs, seg_onehot, rest;
    logic [CNT_W-1:0] cnt_reg, cnt_next, seg_end, addr_idx;
    logic [2:0]       bit_sel;
    logic             active, have, advance, seg_done;

    logic       m_valid_reg, m_valid_next;
    logic       sel_reg, sel_next;
    logic       clk_reg, clk_next;
    logic       mosi_reg, mosi_next;
    logic       samp_reg, samp_next;
    logic       wait_reg, wait_next;
    logic [7:0] rv_reg, rv_next;
    logic       rvalid_reg, rvalid_next;
    logic       last_reg, last_next;

    assign active   = (segs_reg != '0);
    assign cur      = active ? desc_reg : q_desc;
    assign cur_segs = active ? segs_reg : q_desc.segs;
    assign have     = active || q_valid;
    assign advance  = !m_valid_reg || m_ready;
    assign q_pop    = advance && !active && q_valid;

    // The segment being played is the lowest one still pending.
    assign seg_onehot = cur_segs & (~cur_segs + seg_mask_t'(1));
    assign rest       = cur_segs & ~seg_onehot;
    assign bit_sel    = 3'd7 - cnt_reg[2:0];
    assign addr_idx   = CNT_W'(ADDRESS_BITS - 1) - cnt_reg;
    assign seg_done   = (cnt_reg == seg_end);

    // Cell generation for the current segment.
    always_comb begin
        sel_next    = 1'b0;
        clk_next    = 1'b1;
        mosi_next   = 1'b0;
        samp_next   = 1'b0;
        wait_next   = 1'b0;
        rv_next     = 8'd0;
        rvalid_next = 1'b0;
        seg_end     = '0;
        case (seg_onehot)
            SEG_DATA_FIRST, SEG_DATA_LAST: begin
                mosi_next = cur.data[bit_sel];
                seg_end   = CNT_W'(7);
            end
            SEG_WAIT: begin
                sel_next  = 1'b1;
                clk_next  = 1'b0;
                wait_next = 1'b1;
            end
            SEG_WREN: begin
                seg_end = CNT_W'(8);
                if (cnt_reg == CNT_W'(8)) begin
                    sel_next = 1'b1;
                    clk_next = 1'b0;
                end else begin
                    mosi_next = OP_WREN[bit_sel];
                end
            end
            SEG_OPCODE: begin
                mosi_next = cur.opcode[bit_sel];
                seg_end   = CNT_W'(7);
            end
            SEG_ADDRESS: begin
                seg_end = CNT_W'(ADDRESS_BITS - 1);
                if (int'(addr_idx) < 16) begin
                    mosi_next = cur.address[addr_idx[3:0]];
                end
            end
            SEG_DESELECT: begin
                sel_next = 1'b1;
                clk_next = 1'b0;
            end
            SEG_SAMPLE: begin
                samp_next = 1'b1;
            end
            SEG_READ_DONE: begin
                sel_next    = 1'b1;
                clk_next    = 1'b0;
                rv_next     = cur.read_value;
                rvalid_next = 1'b1;
            end
            default: begin
                sel_next = 1'b1;
                clk_next = 1'b0;
            end
        endcase
    end

    // Sequencing through segments and the output register.
    always_comb begin
        segs_next    = segs_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        last_next    = last_reg;
        if (advance) begin
            m_valid_next = have;
            if (have) begin
                segs_next = seg_done ? rest : cur_segs;
                cnt_next  = seg_done ? '0 : cnt_reg + CNT_W'(1);
                last_next = seg_done && (rest == '0);
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segs_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            segs_reg    <= segs_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (advance && have) begin
            desc_reg   <= cur;
            sel_reg    <= sel_next;
            clk_reg    <= clk_next;
            mosi_reg   <= mosi_next;
            samp_reg   <= samp_next;
            wait_reg   <= wait_next;
            rv_reg     <= rv_next;
            rvalid_reg <= rvalid_next;
        end
        last_reg <= last_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_select_level     = sel_reg;
    assign m_clock_pulse      = clk_reg;
    assign m_mosi_level       = mosi_reg;
    assign m_sample_cell      = samp_reg;
    assign m_wait_write_cycle = wait_reg;
    assign m_read_value       = rv_reg;
    assign m_read_valid       = rvalid_reg;
    assign m_last             = last_reg;

endmodule

// ===== tb/eeprom_cell_checker.sv =====
module eeprom_cell_checker
    import sesq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic        s_last_byte,
    input  logic        s_miso_bit,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_select_level,
    input  logic        m_clock_pulse,
    input  logic        m_mosi_level,
    input  logic        m_sample_cell,
    input  logic        m_wait_write_cycle,
    input  logic [7:0]  m_read_value,
    input  logic        m_read_valid,
    input  logic        m_last,
    output int          fail_count,
    output int          outstanding,
    output int          cells_checked,
    output int          page_restarts,
    output int          reads_done
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_SIZE  = 16;
    localparam int ADDR_WIDTH = 16;

    // One serial bit cell as the block should emit it.
    typedef struct packed {
        logic       cs_high;
        logic       sclk;
        logic       mosi;
        logic       sample_cell;
        logic       write_wait;
        logic [7:0] read_byte;
        logic       read_done;
        logic       final_cell;
    } spi_cell_t;

    spi_cell_t   expected_cells[$];
    spi_cell_t   request_cells[$];

    // Shadow of the sequencer state.
    logic [15:0] run_address;
    logic        run_open;
    logic [3:0]  bits_pending;
    logic [7:0]  shift_in;

    int errors;
    int checked;
    int restarts;
    int reads;

    initial begin
        errors   = 0;
        checked  = 0;
        restarts = 0;
        reads    = 0;
    end

    task automatic add_cell(input logic sel, input logic clk, input logic mosi,
                            input logic samp, input logic wr_wait,
                            input logic [7:0] rv, input logic rd_done);
        spi_cell_t c;
        c.cs_high     = sel;
        c.sclk        = clk;
        c.mosi        = mosi;
        c.sample_cell = samp;
        c.write_wait  = wr_wait;
        c.read_byte   = rv;
        c.read_done   = rd_done;
        c.final_cell  = 1'b0;
        request_cells.push_back(c);
    endtask

    // Clock cells carrying a value MSB first.
    task automatic clock_out(input logic [23:0] value, input int nbits);
        for (int i = nbits - 1; i >= 0; i--) begin
            add_cell(1'b0, 1'b1, value[i], 1'b0, 1'b0, 8'h00, 1'b0);
        end
    endtask

    task automatic deselect_cell(input logic wr_wait);
        add_cell(1'b1, 1'b0, 1'b0, 1'b0, wr_wait, 8'h00, 1'b0);
    endtask

    task automatic enable_frame();
        clock_out({16'h0000, OP_WREN}, 8);
        deselect_cell(1'b0);
    endtask

    task automatic command_header(input logic [7:0] opcode, input logic [15:0] addr);
        clock_out({16'h0000, opcode}, 8);
        clock_out({8'h00, addr}, ADDR_WIDTH);
    endtask

    // Works out the cells that one accepted request causes.
    task automatic predict_cells(input logic [2:0] mode, input logic [15:0] addr,
                                 input logic [7:0] data, input logic lastb,
                                 input logic miso);
        spi_cell_t c;
        logic      boundary;
        request_cells.delete();
        if (bits_pending != 4'd0) begin
            // A read is waiting for its bits; everything else is dropped.
            if (mode == MODE_MISO_BIT) begin
                shift_in     = {shift_in[6:0], miso};
                bits_pending = bits_pending - 4'd1;
                add_cell(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
                if (bits_pending == 4'd0) begin
                    add_cell(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, shift_in, 1'b1);
                    reads++;
                end
            end
        end else if (run_open) begin
            // Inside a burst only burst bytes count.
            if (mode == MODE_BURST_BYTE) begin
                boundary = (run_address % PAGE_SIZE) == (PAGE_SIZE - 1);
                clock_out({16'h0000, data}, 8);
                run_address = run_address + 16'd1;
                if (lastb) begin
                    deselect_cell(1'b0);
                    run_open = 1'b0;
                end else if (boundary) begin
                    deselect_cell(1'b1);
                    enable_frame();
                    command_header(OP_WRITE, run_address);
                    restarts++;
                end
            end
        end else begin
            case (mode)
                MODE_WREN: begin
                    enable_frame();
                end
                MODE_WRITE: begin
                    enable_frame();
                    command_header(OP_WRITE, addr);
                    clock_out({16'h0000, data}, 8);
                    deselect_cell(1'b0);
                end
                MODE_READ: begin
                    command_header(OP_READ, addr);
                    bits_pending = READ_BITS;
                    shift_in     = 8'h00;
                end
                MODE_RDSR: begin
                    clock_out({16'h0000, OP_RDSR}, 8);
                    bits_pending = READ_BITS;
                    shift_in     = 8'h00;
                end
                MODE_BURST_START: begin
                    enable_frame();
                    command_header(OP_WRITE, addr);
                    run_address = addr;
                    run_open    = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (request_cells.size() > 0) begin
            c = request_cells[request_cells.size() - 1];
            c.final_cell = 1'b1;
            request_cells[request_cells.size() - 1] = c;
        end
        foreach (request_cells[i]) expected_cells.push_back(request_cells[i]);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Predict on every input transfer and check every output transfer.
    always @(posedge aclk) begin
        spi_cell_t want;
        if (!aresetn) begin
            expected_cells.delete();
            run_address  = 16'h0000;
            run_open     = 1'b0;
            bits_pending = 4'd0;
            shift_in     = 8'h00;
        end else begin
            if (s_valid && s_ready) begin
                predict_cells(s_mode, s_address, s_write_data, s_last_byte, s_miso_bit);
            end
            if (m_valid && m_ready) begin
                if (expected_cells.size() == 0) begin
                    $display("%0t: cell transfer with none expected, actual sel %0b clk %0b mosi %0b",
                             $time, m_select_level, m_clock_pulse, m_mosi_level);
                    errors++;
                end else begin
                    want = expected_cells.pop_front();
                    compare_field("select_level", want.cs_high, m_select_level);
                    compare_field("clock_pulse", want.sclk, m_clock_pulse);
                    compare_field("mosi_level", want.mosi, m_mosi_level);
                    compare_field("sample_cell", want.sample_cell, m_sample_cell);
                    compare_field("wait_write_cycle", want.write_wait, m_wait_write_cycle);
                    compare_field("read_value", want.read_byte, m_read_value);
                    compare_field("read_valid", want.read_done, m_read_valid);
                    compare_field("last", want.final_cell, m_last);
                    checked++;
                end
            end
        end
        fail_count    <= errors;
        outstanding   <= expected_cells.size();
        cells_checked <= checked;
        page_restarts <= restarts;
        reads_done    <= reads;
    end

endmodule

// ===== tb/spi_eeprom_command_sequencer_tb.sv =====
module spi_eeprom_command_sequencer_tb
    import sesq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_UNDEFINED = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 235;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_mode;
    logic [15:0] s_address;
    logic [7:0]  s_write_data;
    logic        s_last_byte;
    logic        s_miso_bit;
    logic        m_valid;
    logic        m_ready;
    logic        m_select_level;
    logic        m_clock_pulse;
    logic        m_mosi_level;
    logic        m_sample_cell;
    logic        m_wait_write_cycle;
    logic [7:0]  m_read_value;
    logic        m_read_valid;
    logic        m_last;

    int fail_count;
    int outstanding;
    int cells_checked;
    int page_restarts;
    int reads_done;

    int   request_count;
    int   cycle_count;
    logic calm;
    logic rx_hold_request;

    spi_eeprom_command_sequencer #(
        .PAGE_BYTES   (16),
        .ADDRESS_BITS (16)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_address          (s_address),
        .s_write_data       (s_write_data),
        .s_last_byte        (s_last_byte),
        .s_miso_bit         (s_miso_bit),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_select_level     (m_select_level),
        .m_clock_pulse      (m_clock_pulse),
        .m_mosi_level       (m_mosi_level),
        .m_sample_cell      (m_sample_cell),
        .m_wait_write_cycle (m_wait_write_cycle),
        .m_read_value       (m_read_value),
        .m_read_valid       (m_read_valid),
        .m_last             (m_last)
    );

    eeprom_cell_checker cell_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_address          (s_address),
        .s_write_data       (s_write_data),
        .s_last_byte        (s_last_byte),
        .s_miso_bit         (s_miso_bit),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_select_level     (m_select_level),
        .m_clock_pulse      (m_clock_pulse),
        .m_mosi_level       (m_mosi_level),
        .m_sample_cell      (m_sample_cell),
        .m_wait_write_cycle (m_wait_write_cycle),
        .m_read_value       (m_read_value),
        .m_read_valid       (m_read_valid),
        .m_last             (m_last),
        .fail_count         (fail_count),
        .outstanding        (outstanding),
        .cells_checked      (cells_checked),
        .page_restarts      (page_restarts),
        .reads_done         (reads_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d cells pending", cycle_count, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // Cell receiver: random back-pressure, one long hold-off on request.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 11);
            end
        end
    end

    // Offers one request and waits for its transfer.
    task automatic send_item(input logic [2:0] mode, input logic [15:0] addr,
                             input logic [7:0] data, input logic lastb, input logic miso);
        while (!calm && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_address    <= addr;
        s_write_data <= data;
        s_last_byte  <= lastb;
        s_miso_bit   <= miso;
        do @(posedge aclk); while (!s_ready);
        request_count++;
    endtask

    task automatic send_noise(input logic [2:0] mode);
        send_item(mode, 16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    function automatic logic [2:0] other_mode(input logic [2:0] keep);
        logic [2:0] m;
        m = 3'($urandom_range(7));
        if (m == keep) m = MODE_UNDEFINED;
        return m;
    endfunction

    function automatic logic [15:0] random_address();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 16'h0000;
        if (r < 16) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Read or status read followed by its eight bits, with the odd ignored request.
    task automatic read_sequence(input logic status);
        send_item(status ? MODE_RDSR : MODE_READ, random_address(), 8'($urandom),
                  1'($urandom), 1'($urandom));
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(99) < 8) send_noise(other_mode(MODE_MISO_BIT));
            send_noise(MODE_MISO_BIT);
        end
    endtask

    // Burst start and its bytes, often placed close to a page end.
    task automatic burst_sequence();
        logic [15:0] addr;
        int          nbytes;
        addr = random_address();
        if ($urandom_range(1) == 1) addr[3:0] = 4'hC + 4'($urandom_range(3));
        nbytes = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 20);
        send_item(MODE_BURST_START, addr, 8'($urandom), 1'($urandom), 1'($urandom));
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(99) < 6) send_noise(other_mode(MODE_BURST_BYTE));
            send_item(MODE_BURST_BYTE, 16'($urandom), 8'($urandom), i == nbytes - 1,
                      1'($urandom));
        end
    endtask

    initial begin
        int random_start;
        int progress;
        int pick;
        bit hold_asked;
        bit paused;
        hold_asked    = 1'b0;
        paused        = 1'b0;
        request_count = 0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_mode          <= MODE_WREN;
        s_address       <= 16'h0000;
        s_write_data    <= 8'h00;
        s_last_byte     <= 1'b0;
        s_miso_bit      <= 1'b0;
        calm            <= 1'b0;
        rx_hold_request <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: field extremes, each request kind and the ignored cases.
        send_item(MODE_WREN, 16'h0000, 8'h00, 1'b0, 1'b0);
        send_item(MODE_WRITE, 16'h0000, 8'h00, 1'b0, 1'b0);
        send_item(MODE_WRITE, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        send_item(MODE_MISO_BIT, 16'h1234, 8'h5A, 1'b0, 1'b1);
        send_item(MODE_BURST_BYTE, 16'h0000, 8'hA5, 1'b1, 1'b0);
        send_item(MODE_UNDEFINED, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        send_item(MODE_READ, 16'hFFFF, 8'h00, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) send_item(MODE_MISO_BIT, 16'h0000, 8'h00, 1'b0, 1'b1);
        send_item(MODE_WRITE, 16'h0040, 8'h11, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) send_item(MODE_MISO_BIT, 16'h0000, 8'h00, 1'b0, 1'b0);
        send_item(MODE_RDSR, 16'h0000, 8'h00, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++) send_item(MODE_MISO_BIT, 16'hFFFF, 8'hFF, 1'b0, 1'(i));
        // Burst across the top of the address space, restarting at zero.
        send_item(MODE_BURST_START, 16'hFFFE, 8'h00, 1'b0, 1'b0);
        send_item(MODE_BURST_BYTE, 16'h0000, 8'h81, 1'b0, 1'b0);
        send_item(MODE_READ, 16'h0100, 8'h00, 1'b0, 1'b0);
        send_item(MODE_BURST_BYTE, 16'h0000, 8'h7E, 1'b0, 1'b0);
        send_item(MODE_BURST_BYTE, 16'h0000, 8'hC3, 1'b1, 1'b0);
        // Final byte on the last slot of a page closes without a restart.
        send_item(MODE_BURST_START, 16'h001F, 8'h00, 1'b0, 1'b0);
        send_item(MODE_BURST_BYTE, 16'h0000, 8'h3C, 1'b1, 1'b0);

        // Random well-formed sequences with some stray requests mixed in.
        random_start = request_count;
        while (request_count - random_start < RANDOM_ITEMS) begin
            progress = request_count - random_start;
            if (progress >= 60 && !hold_asked) begin
                hold_asked = 1'b1;
                rx_hold_request <= 1'b1;
            end
            if (progress >= 150 && !paused) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (outstanding != 0);
            end
            calm <= (progress >= 190 && progress < 230);
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_noise(MODE_WREN);
            end else if (pick < 30) begin
                send_item(MODE_WRITE, random_address(), 8'($urandom), 1'($urandom),
                          1'($urandom));
            end else if (pick < 48) begin
                read_sequence(1'b0);
            end else if (pick < 62) begin
                read_sequence(1'b1);
            end else if (pick < 90) begin
                burst_sequence();
            end else begin
                case ($urandom_range(2))
                    0: send_noise(MODE_BURST_BYTE);
                    1: send_noise(MODE_MISO_BIT);
                    default: send_noise(MODE_UNDEFINED);
                endcase
            end
        end

        // Let every cell drain, then allow for any late extra cell.
        s_valid <= 1'b0;
        calm    <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d cells,", request_count, cells_checked);
        $display("including %0d completed reads and %0d burst page restarts.",
                 reads_done, page_restarts);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
